### rtl/cfl_pkg.sv
// Shared types, constants and helpers for the CFL time step limiter.
// No dependencies; the limiter and the arithmetic units import this package.
`default_nettype none
package cfl_pkg;

   localparam int STEP_W = 8;                  // width of the serial step counters

   // serial step counts of the shared units
   localparam logic [STEP_W-1:0] MUL_STEPS      = 8'd32;
   localparam logic [STEP_W-1:0] DIV_STEPS_96   = 8'd96;
   localparam logic [STEP_W-1:0] DIV_STEPS_128  = 8'd128;
   localparam logic [STEP_W-1:0] SQRT_STEPS_64  = 8'd32;
   localparam logic [STEP_W-1:0] SQRT_STEPS_128 = 8'd64;

   localparam logic [2:0]  MAX_SURFACES = 3'd4;
   localparam logic [31:0] TWO_PI_Q16   = 32'd411775;
   localparam logic [63:0] CAP_LIMIT    = 64'd429496729600000000;
   localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

   // register indexes of the csr port
   localparam logic [2:0] CSR_CFL_MAX       = 3'd0;
   localparam logic [2:0] CSR_SURFACE_COUNT = 3'd1;
   localparam logic [2:0] CSR_TENSION_0     = 3'd2;
   localparam logic [2:0] CSR_TENSION_1     = 3'd3;
   localparam logic [2:0] CSR_TENSION_2     = 3'd4;
   localparam logic [2:0] CSR_TENSION_3     = 3'd5;
   localparam logic [2:0] CSR_START_LIMIT   = 3'd6;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      logic [31:0] neg;
      neg = ~v + 32'd1;
      return v[31] ? neg : v;
   endfunction

   function automatic logic [63:0] min64(input logic [63:0] a, input logic [63:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage
`default_nettype wire

### rtl/cfl_ifc.sv
// Valid/ready channel interfaces for cell requests and step limit responses.
// No dependencies.
`default_nettype none
interface cfl_req_if;
   logic               valid;
   logic               ready;
   logic               restart;
   logic        [31:0] largest_area;
   logic        [31:0] smallest_area;
   logic        [31:0] cell_volume;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic        [31:0] viscosity;
   logic        [31:0] density;

   modport source (output valid, restart, largest_area, smallest_area, cell_volume,
                   vel_x, vel_y, vel_z, viscosity, density, input ready);
   modport sink   (input valid, restart, largest_area, smallest_area, cell_volume,
                   vel_x, vel_y, vel_z, viscosity, density, output ready);
endinterface

interface cfl_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] step_limit;

   modport source (output valid, step_limit, input ready);
   modport sink   (input valid, step_limit, output ready);
endinterface
`default_nettype wire

### rtl/cfl_time_step_limit.sv
// CFL time step limiter: one cell per request, one running-minimum step per response.
// A new cell is accepted only in the idle state, so one cell is processed at a time; the
// sequence runs on the shared bit-serial multiplier, divider and root unit, used one at a
// time; a zero divisor skips its division.
// Reset (synchronous, active high): registers to their reset values, running limit all ones.
// Depends on cfl_pkg, cfl_ifc, cfl_mul, cfl_div, cfl_sqrt.
`default_nettype none
module cfl_time_step_limit (
   input  wire logic        clock,
   input  wire logic        reset,
   cfl_req_if.sink          req_chan,
   cfl_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   import cfl_pkg::*;

   // one step of the sequencer per arithmetic operation
   typedef enum logic [16:0] {
      ST_IDLE = 17'h00001,
      ST_SQX  = 17'h00002,   // vx^2
      ST_SQY  = 17'h00004,   // + vy^2
      ST_SQZ  = 17'h00008,   // + vz^2
      ST_SPD  = 17'h00010,   // speed = sqrt
      ST_AS   = 17'h00020,   // A * speed
      ST_CV   = 17'h00040,   // C * V
      ST_CDIV = 17'h00080,   // convective quotient
      ST_CA   = 17'h00100,   // C * a
      ST_CAR  = 17'h00200,   // * rho
      ST_VDIV = 17'h00400,   // viscous quotient
      ST_RV   = 17'h00800,   // rho * V
      ST_PS   = 17'h01000,   // 2pi * sigma
      ST_XDIV = 17'h02000,   // capillary radicand
      ST_XSQ  = 17'h04000,   // its root
      ST_CR   = 17'h08000,   // C * root
      ST_FIN  = 17'h10000    // fold into running limit, load response
   } state_type;

   // configuration
   logic [31:0] cfl_ff;
   logic [2:0]  scount_ff;
   logic [31:0] tension_ff [4];
   logic [63:0] start_ff;

   state_type   state_ff, state_in;
   logic        launched_ff, launched_in;
   logic [2:0]  k_ff, k_in;
   logic [63:0] running_ff, running_in;
   logic [63:0] best_ff, best_in;
   logic [63:0] as_ff, as_in;
   logic [63:0] rv_ff, rv_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   // latched cell
   logic [31:0] big_a_ff, small_a_ff, vol_ff, mx_ff, my_ff, mz_ff, mu_ff, rho_ff;

   unit_ctl_type mul_ctl, div_ctl, sqrt_ctl;
   unit_sts_type mul_sts, div_sts, sqrt_sts;
   logic         mul_accum;
   logic [63:0]  mul_a;
   logic [31:0]  mul_b;
   logic [95:0]  mul_prod;
   logic [127:0] div_num, div_quo;
   logic [63:0]  div_den;
   logic [127:0] sqrt_rad;
   logic [63:0]  sqrt_root;

   logic         req_xfer;
   logic         rsp_xfer;
   logic [2:0]   cnt_lim;
   logic [31:0]  sigma;
   logic [34:0]  six_mu;
   logic [63:0]  quo_sat;
   logic [63:0]  cap_term;
   logic         last_k;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_valid_ff && rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.step_limit = rsp_data_ff;

   assign cnt_lim  = (scount_ff > MAX_SURFACES) ? MAX_SURFACES : scount_ff;
   assign sigma    = tension_ff[k_ff[1:0]];
   assign six_mu   = {1'b0, mu_ff, 2'b00} + {2'b00, mu_ff, 1'b0};
   assign quo_sat  = (div_quo[127:64] != '0) ? ALL_ONES : div_quo[63:0];
   // term = C*root / 2^16, saturating past 64 bits
   assign cap_term = (mul_prod[95:80] != '0) ? ALL_ONES : mul_prod[79:16];
   assign last_k   = ((k_ff + 3'd1) == cnt_lim);

   // csr writes; software writes only while idle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfl_ff        <= 32'd65536;
         scount_ff     <= 3'd0;
         tension_ff[0] <= 32'd65536;
         tension_ff[1] <= 32'd65536;
         tension_ff[2] <= 32'd65536;
         tension_ff[3] <= 32'd65536;
         start_ff      <= ALL_ONES;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CFL_MAX:       cfl_ff        <= csr_wdata[31:0];
            CSR_SURFACE_COUNT: scount_ff     <= csr_wdata[2:0];
            CSR_TENSION_0:     tension_ff[0] <= csr_wdata[31:0];
            CSR_TENSION_1:     tension_ff[1] <= csr_wdata[31:0];
            CSR_TENSION_2:     tension_ff[2] <= csr_wdata[31:0];
            CSR_TENSION_3:     tension_ff[3] <= csr_wdata[31:0];
            CSR_START_LIMIT:   start_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer: each op state launches its unit once, then waits for done, unless a zero divisor or tension skips it
   always_comb begin
      state_in     = state_ff;
      launched_in  = launched_ff;
      k_in         = k_ff;
      running_in   = running_ff;
      best_in      = best_ff;
      as_in        = as_ff;
      rv_in        = rv_ff;
      rsp_valid_in = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_ctl      = '{start: 1'b0, steps: MUL_STEPS};
      div_ctl      = '{start: 1'b0, steps: DIV_STEPS_128};
      sqrt_ctl     = '{start: 1'b0, steps: SQRT_STEPS_128};
      mul_accum    = 1'b0;
      mul_a        = {32'd0, mx_ff};
      mul_b        = mx_ff;
      div_num      = {mul_prod[63:0], 64'd0};
      div_den      = as_ff;
      sqrt_rad     = div_quo;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_chan.restart) running_in = start_ff;
               best_in  = CAP_LIMIT;
               state_in = ST_SQX;
            end
         end
         ST_SQX, ST_SQY, ST_SQZ: begin
            mul_accum = (state_ff != ST_SQX);
            if (state_ff == ST_SQY) begin
               mul_a = {32'd0, my_ff};
               mul_b = my_ff;
            end else if (state_ff == ST_SQZ) begin
               mul_a = {32'd0, mz_ff};
               mul_b = mz_ff;
            end
            if (!launched_ff) begin
               mul_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (mul_sts.done) begin
               launched_in = 1'b0;
               state_in    = (state_ff == ST_SQX) ? ST_SQY :
                             (state_ff == ST_SQY) ? ST_SQZ : ST_SPD;
            end
         end
         ST_SPD: begin
            sqrt_rad       = {mul_prod[63:0], 64'd0};
            sqrt_ctl.steps = SQRT_STEPS_64;
            if (!launched_ff) begin
               sqrt_ctl.start = 1'b1;
               launched_in    = 1'b1;
            end else if (sqrt_sts.done) begin
               launched_in = 1'b0;
               state_in    = ST_AS;
            end
         end
         ST_AS: begin
            mul_a = {32'd0, big_a_ff};
            mul_b = sqrt_root[31:0];
            if (!launched_ff) begin
               mul_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (mul_sts.done) begin
               launched_in = 1'b0;
               as_in       = mul_prod[63:0];
               state_in    = ST_CV;
            end
         end
         ST_CV: begin
            mul_a = {32'd0, cfl_ff};
            mul_b = vol_ff;
            if (!launched_ff) begin
               mul_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (mul_sts.done) begin
               launched_in = 1'b0;
               state_in    = ST_CDIV;
            end
         end
         ST_CDIV: begin
            // C*V*2^32 as a 96-bit dividend, left-aligned
            div_ctl.steps = DIV_STEPS_96;
            if (as_ff == '0) begin
               state_in = ST_CA;     // saturated quotient cannot lower the minimum
            end else if (!launched_ff) begin
               div_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (div_sts.done) begin
               launched_in = 1'b0;
               best_in     = min64(best_ff, quo_sat);
               state_in    = ST_CA;
            end
         end
         ST_CA: begin
            mul_a = {32'd0, cfl_ff};
            mul_b = small_a_ff;
            if (!launched_ff) begin
               mul_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (mul_sts.done) begin
               launched_in = 1'b0;
               state_in    = ST_CAR;
            end
         end
         ST_CAR: begin
            mul_a = mul_prod[63:0];
            mul_b = rho_ff;
            if (!launched_ff) begin
               mul_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (mul_sts.done) begin
               launched_in = 1'b0;
               state_in    = ST_VDIV;
            end
         end
         ST_VDIV: begin
            div_num       = {mul_prod, 32'd0};
            div_den       = {29'd0, six_mu};
            div_ctl.steps = DIV_STEPS_96;
            if (mu_ff == '0) begin
               state_in = (cnt_lim == 3'd0) ? ST_FIN : ST_RV;
            end else if (!launched_ff) begin
               div_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (div_sts.done) begin
               launched_in = 1'b0;
               best_in     = min64(best_ff, quo_sat);
               state_in    = (cnt_lim == 3'd0) ? ST_FIN : ST_RV;
            end
         end
         ST_RV: begin
            mul_a = {32'd0, rho_ff};
            mul_b = vol_ff;
            if (!launched_ff) begin
               mul_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (mul_sts.done) begin
               launched_in = 1'b0;
               rv_in       = mul_prod[63:0];
               k_in        = 3'd0;
               state_in    = ST_PS;
            end
         end
         ST_PS: begin
            mul_a = {32'd0, sigma};
            mul_b = TWO_PI_Q16;
            if (sigma == '0) begin
               // zero tension: skipped, cap stays
               k_in     = k_ff + 3'd1;
               state_in = last_k ? ST_FIN : ST_PS;
            end else if (!launched_ff) begin
               mul_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (mul_sts.done) begin
               launched_in = 1'b0;
               state_in    = ST_XDIV;
            end
         end
         ST_XDIV: begin
            div_num = {rv_ff, 64'd0};
            div_den = mul_prod[63:0];
            if (!launched_ff) begin
               div_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (div_sts.done) begin
               launched_in = 1'b0;
               state_in    = ST_XSQ;
            end
         end
         ST_XSQ: begin
            if (!launched_ff) begin
               sqrt_ctl.start = 1'b1;
               launched_in    = 1'b1;
            end else if (sqrt_sts.done) begin
               launched_in = 1'b0;
               state_in    = ST_CR;
            end
         end
         ST_CR: begin
            mul_a = sqrt_root;
            mul_b = cfl_ff;
            if (!launched_ff) begin
               mul_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (mul_sts.done) begin
               launched_in = 1'b0;
               best_in     = min64(best_ff, cap_term);
               k_in        = k_ff + 3'd1;
               state_in    = last_k ? ST_FIN : ST_PS;
            end
         end
         ST_FIN: begin
            // hold while the previous response is still waiting
            if (!rsp_valid_ff || rsp_chan.ready) begin
               running_in   = min64(running_ff, best_ff);
               rsp_data_in  = min64(running_ff, best_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in    = ST_IDLE;
            launched_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         running_ff   <= ALL_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      best_ff     <= best_in;
      as_ff       <= as_in;
      rv_ff       <= rv_in;
      rsp_data_ff <= rsp_data_in;
      if (req_xfer) begin
         big_a_ff   <= req_chan.largest_area;
         small_a_ff <= req_chan.smallest_area;
         vol_ff     <= req_chan.cell_volume;
         mx_ff      <= mag32(req_chan.vel_x);
         my_ff      <= mag32(req_chan.vel_y);
         mz_ff      <= mag32(req_chan.vel_z);
         mu_ff      <= req_chan.viscosity;
         rho_ff     <= req_chan.density;
      end
   end

   cfl_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .accum (mul_accum),
      .mcand (mul_a),
      .mult  (mul_b),
      .sts   (mul_sts),
      .prod  (mul_prod)
   );

   cfl_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_sts),
      .quo   (div_quo)
   );

   cfl_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .ctl   (sqrt_ctl),
      .rad   (sqrt_rad),
      .sts   (sqrt_sts),
      .root  (sqrt_root)
   );

   // the units are used strictly one at a time
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_sts.busy, div_sts.busy, sqrt_sts.busy}))
      else $error("more than one arithmetic unit busy");

   // running limit only rises on a restart transfer
   a_run_mono: assert property (@(posedge clock) disable iff (reset)
      (running_ff > $past(running_ff)) |-> $past(req_xfer && req_chan.restart))
      else $error("running limit rose without restart");

   // the per-cell minimum never exceeds the capillary cap
   a_best_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> (best_ff <= CAP_LIMIT))
      else $error("cell minimum above cap");

   // a response appears only from the final step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside final step");
endmodule
`default_nettype wire

### rtl/cfl_mul.sv
// Bit-serial shift-add multiplier: 64-bit multiplicand by 32-bit multiplier.
// Depends on cfl_pkg.
`default_nettype none
module cfl_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfl_pkg::unit_ctl_type ctl,
   input  wire logic                  accum,
   input  wire logic [63:0]           mcand,
   input  wire logic [31:0]           mult,
   output      cfl_pkg::unit_sts_type sts,
   output      logic [95:0]           prod
);
   import cfl_pkg::*;

   logic [STEP_W-1:0] cnt_ff;
   logic              done_ff;
   logic [95:0]       acc_ff;
   logic [95:0]       msh_ff;
   logic [31:0]       mult_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == STEP_W'(1));
         if (ctl.start) cnt_ff <= ctl.steps;
         else if (cnt_ff != '0) cnt_ff <= cnt_ff - STEP_W'(1);
      end
   end

   // LSB first; accumulation lets a sum of squares build up
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         if (!accum) acc_ff <= '0;
         msh_ff  <= {32'd0, mcand};
         mult_ff <= mult;
      end else if (cnt_ff != '0) begin
         if (mult_ff[0]) acc_ff <= acc_ff + msh_ff;
         msh_ff  <= {msh_ff[94:0], 1'b0};
         mult_ff <= {1'b0, mult_ff[31:1]};
      end
   end

   assign prod     = acc_ff;
   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
endmodule
`default_nettype wire

### rtl/cfl_div.sv
// Restoring radix-2 divider: left-aligned 128-bit dividend by 64-bit divisor,
// full 128-bit quotient. Depends on cfl_pkg.
`default_nettype none
module cfl_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfl_pkg::unit_ctl_type ctl,
   input  wire logic [127:0]          num,
   input  wire logic [63:0]           den,
   output      cfl_pkg::unit_sts_type sts,
   output      logic [127:0]          quo
);
   import cfl_pkg::*;

   logic [STEP_W-1:0] cnt_ff;
   logic              done_ff;
   logic [127:0]      num_ff;
   logic [63:0]       den_ff;
   logic [63:0]       rem_ff;
   logic [127:0]      quo_ff;
   logic [64:0]       rem_sh;
   logic [64:0]       rem_sub;
   logic              qbit;

   assign rem_sh  = {rem_ff, num_ff[127]};
   assign qbit    = (rem_sh >= {1'b0, den_ff});
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == STEP_W'(1));
         if (ctl.start) cnt_ff <= ctl.steps;
         else if (cnt_ff != '0) cnt_ff <= cnt_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         num_ff <= {num_ff[126:0], 1'b0};
         rem_ff <= qbit ? rem_sub[63:0] : rem_sh[63:0];
         quo_ff <= {quo_ff[126:0], qbit};
      end
   end

   assign quo      = quo_ff;
   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
endmodule
`default_nettype wire

### rtl/cfl_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per step.
// Radicand is left-aligned in 128 bits. Depends on cfl_pkg.
`default_nettype none
module cfl_sqrt (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfl_pkg::unit_ctl_type ctl,
   input  wire logic [127:0]          rad,
   output      cfl_pkg::unit_sts_type sts,
   output      logic [63:0]           root
);
   import cfl_pkg::*;

   logic [STEP_W-1:0] cnt_ff;
   logic              done_ff;
   logic [127:0]      rad_ff;
   logic [65:0]       rem_ff;
   logic [63:0]       root_ff;
   logic [67:0]       trial;
   logic [67:0]       tsub;
   logic [67:0]       tdiff;
   logic              take;

   assign trial = {rem_ff, rad_ff[127:126]};
   assign tsub  = {2'b00, root_ff, 2'b01};
   assign take  = (trial >= tsub);
   assign tdiff = trial - tsub;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == STEP_W'(1));
         if (ctl.start) cnt_ff <= ctl.steps;
         else if (cnt_ff != '0) cnt_ff <= cnt_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rad_ff  <= rad;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cnt_ff != '0) begin
         rad_ff  <= {rad_ff[125:0], 2'b00};
         rem_ff  <= take ? tdiff[65:0] : trial[65:0];
         root_ff <= {root_ff[62:0], take};
      end
   end

   assign root     = root_ff;
   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
endmodule
`default_nettype wire
